// ===== hdl/gfrtb_pkg.sv =====
package gfrtb_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned PROC_W = 7;
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned DVD_W  = 16;
  localparam int unsigned STEP_W = 5;

  // Divider step counts: the window excess has 9 significant bits
  localparam logic [STEP_W-1:0] EXCESS_STEPS = 5'd9;
  localparam logic [STEP_W-1:0] SUM_STEPS    = 5'd16;
  localparam int unsigned       EXCESS_SHIFT = 7;

  localparam logic [PROC_W-1:0] PROC_RESET = 7'd2;

  typedef struct packed {
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] p;
    logic [VAL_W-1:0] r;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [VAL_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DVD_W-1:0] quot;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_X,
    S_XWAIT,
    S_ACC,
    S_MSTART,
    S_MWAIT,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ===== hdl/gfrtb_store.sv =====
module gfrtb_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  gfrtb_pkg::entry_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output gfrtb_pkg::entry_t rdata
);

  gfrtb_pkg::entry_t mem [DEPTH];

  // Write one task, read one task, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gfrtb_div.sv =====
module gfrtb_div (
  input  logic                clk,
  input  logic                rst,
  input  gfrtb_pkg::div_req_t req,
  output gfrtb_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [gfrtb_pkg::STEP_W-1:0]       cnt;
  logic [gfrtb_pkg::DVD_W-1:0]        qd;
  logic [gfrtb_pkg::VAL_W-1:0]        rem;
  logic [gfrtb_pkg::VAL_W-1:0]        dvs;
  logic [gfrtb_pkg::VAL_W:0]          trial;
  logic [gfrtb_pkg::VAL_W:0]          diff;
  logic                               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, qd[gfrtb_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        qd   <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[gfrtb_pkg::VAL_W-1:0] : trial[gfrtb_pkg::VAL_W-1:0];
        qd  <= {qd[gfrtb_pkg::DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == gfrtb_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quot = qd;
  assign rsp.rem  = rem;

endmodule

// ===== hdl/global_fp_response_time_bound_top.sv =====
// Flow: a task at a position below the processor count, or a task past the
// store, goes straight to the output state after acceptance; any other task at
// position n runs through the shared bit-serial divider (9 steps per earlier task
// with nonzero period, 16 steps for the final division by the processor count).
// A stalled result holds the block until it drains.
// Throughput: one task at a time; the next is taken once the result is posted.
// Reset: synchronous, active high; clears the task count, sets processors to 2.
module global_fp_response_time_bound_top #(
  parameter int unsigned MAX_TASKS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [gfrtb_pkg::PROC_W-1:0]   cfg_wr_data,
  input  logic                           task_valid,
  output logic                           task_stall,
  input  logic                           first_task,
  input  logic [gfrtb_pkg::VAL_W-1:0]    exec_time,
  input  logic [gfrtb_pkg::VAL_W-1:0]    period,
  input  logic [gfrtb_pkg::VAL_W-1:0]    deadline,
  input  logic [gfrtb_pkg::VAL_W-1:0]    own_bound,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [gfrtb_pkg::VAL_W-1:0]    bound,
  output logic                           overflow
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned AW = $clog2(MAX_TASKS);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TASKS);

  gfrtb_pkg::state_t state, state_next;

  logic [gfrtb_pkg::PROC_W-1:0] processors;
  logic [gfrtb_pkg::PROC_W-1:0] m;
  logic [CW-1:0]                task_count, task_count_next;
  logic [CW-1:0]                idx, idx_next;
  logic [CW-1:0]                i, i_next;
  logic [CW-1:0]                i_inc;
  logic [CW-1:0]                eff;
  logic [gfrtb_pkg::ACC_W-1:0]  acc, acc_next;
  logic [gfrtb_pkg::VAL_W-1:0]  wc, wc_next;
  logic [gfrtb_pkg::VAL_W-1:0]  wd, wd_next;
  logic [gfrtb_pkg::VAL_W-1:0]  res_bound, res_bound_next;
  logic                         res_ovf, res_ovf_next;
  logic                         result_valid_next;
  logic [gfrtb_pkg::VAL_W-1:0]  bound_next;
  logic                         overflow_next;

  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  gfrtb_pkg::entry_t            st_wdata;
  logic                         st_re;
  gfrtb_pkg::entry_t            st_rdata;

  gfrtb_pkg::div_req_t          div_req;
  gfrtb_pkg::div_rsp_t          div_rsp;

  logic [gfrtb_pkg::VAL_W:0]    pos_sum;
  logic [gfrtb_pkg::VAL_W:0]    neg_sum;
  logic [gfrtb_pkg::VAL_W:0]    excess;
  logic [gfrtb_pkg::VAL_W-1:0]  rem_cap;
  logic [16:0]                  prod;
  logic [17:0]                  ifr_sum;
  logic [gfrtb_pkg::VAL_W-1:0]  contrib;
  logic [16:0]                  fin_sum;

  gfrtb_store #(
    .DEPTH(MAX_TASKS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(i[AW-1:0]),
    .rdata(st_rdata)
  );

  gfrtb_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // Zero processors counts as one
  assign m     = (processors == '0) ? gfrtb_pkg::PROC_W'(1) : processors;
  assign i_inc = i + CW'(1);
  assign eff   = first_task ? '0 : task_count;

  // Window excess of the stored task: max(0, t + R - C - P)
  always_comb begin
    pos_sum = {1'b0, wd} + {1'b0, st_rdata.r};
    neg_sum = {1'b0, st_rdata.c} + {1'b0, st_rdata.p};
    excess  = (pos_sum > neg_sum) ? (pos_sum - neg_sum) : '0;
  end

  // Interference of the stored task, capped at the window
  always_comb begin
    rem_cap = (div_rsp.rem > st_rdata.c) ? st_rdata.c : div_rsp.rem;
    prod    = div_rsp.quot[8:0] * st_rdata.c;
    ifr_sum = 18'(st_rdata.c) + 18'(prod) + 18'(rem_cap);
    contrib = (ifr_sum < 18'(wd)) ? ifr_sum[gfrtb_pkg::VAL_W-1:0] : wd;
    fin_sum = 17'(wc) + 17'(div_rsp.quot);
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_next        = state;
    task_count_next   = task_count;
    idx_next          = idx;
    i_next            = i;
    acc_next          = acc;
    wc_next           = wc;
    wd_next           = wd;
    res_bound_next    = res_bound;
    res_ovf_next      = res_ovf;
    result_valid_next = result_valid && result_stall;
    bound_next        = bound;
    overflow_next     = overflow;
    st_we             = 1'b0;
    st_waddr          = eff[AW-1:0];
    st_wdata          = '{c: exec_time, p: period, r: own_bound};
    st_re             = 1'b0;
    div_req           = '0;
    task_stall        = (state != gfrtb_pkg::S_IDLE);

    unique case (state)
      gfrtb_pkg::S_IDLE: begin
        if (task_valid) begin
          wc_next = exec_time;
          wd_next = deadline;
          if (eff >= MAX_COUNT) begin
            // Store full: flag and drop
            task_count_next = MAX_COUNT;
            res_bound_next  = '0;
            res_ovf_next    = 1'b1;
            state_next      = gfrtb_pkg::S_OUT;
          end else begin
            st_we           = 1'b1;
            task_count_next = eff + CW'(1);
            idx_next        = eff;
            res_ovf_next    = 1'b0;
            if (9'(eff) < 9'(m)) begin
              res_bound_next = exec_time;
              state_next     = gfrtb_pkg::S_OUT;
            end else begin
              i_next     = '0;
              acc_next   = '0;
              state_next = gfrtb_pkg::S_READ;
            end
          end
        end
      end
      gfrtb_pkg::S_READ: begin
        st_re      = 1'b1;
        state_next = gfrtb_pkg::S_X;
      end
      gfrtb_pkg::S_X: begin
        if (st_rdata.p == '0) begin
          // Zero period: the whole window counts
          acc_next   = acc + gfrtb_pkg::ACC_W'(wd);
          i_next     = i_inc;
          state_next = (i_inc == idx) ? gfrtb_pkg::S_MSTART : gfrtb_pkg::S_READ;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {excess, {gfrtb_pkg::EXCESS_SHIFT{1'b0}}};
          div_req.divisor  = st_rdata.p;
          div_req.steps    = gfrtb_pkg::EXCESS_STEPS;
          state_next       = gfrtb_pkg::S_XWAIT;
        end
      end
      gfrtb_pkg::S_XWAIT: begin
        if (div_rsp.done) begin
          state_next = gfrtb_pkg::S_ACC;
        end
      end
      gfrtb_pkg::S_ACC: begin
        acc_next   = acc + gfrtb_pkg::ACC_W'(contrib);
        i_next     = i_inc;
        state_next = (i_inc == idx) ? gfrtb_pkg::S_MSTART : gfrtb_pkg::S_READ;
      end
      gfrtb_pkg::S_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc;
        div_req.divisor  = {1'b0, m};
        div_req.steps    = gfrtb_pkg::SUM_STEPS;
        state_next       = gfrtb_pkg::S_MWAIT;
      end
      gfrtb_pkg::S_MWAIT: begin
        if (div_rsp.done) begin
          state_next = gfrtb_pkg::S_FIN;
        end
      end
      gfrtb_pkg::S_FIN: begin
        res_bound_next = (fin_sum > 17'(wd)) ? wd : fin_sum[gfrtb_pkg::VAL_W-1:0];
        state_next     = gfrtb_pkg::S_OUT;
      end
      gfrtb_pkg::S_OUT: begin
        // Post the result once the output register is free
        if (!result_valid || !result_stall) begin
          result_valid_next = 1'b1;
          bound_next        = res_bound;
          overflow_next     = res_ovf;
          state_next        = gfrtb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gfrtb_pkg::S_IDLE;
      end
    endcase
  end

  // Hold state; control cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gfrtb_pkg::S_IDLE;
      task_count   <= '0;
      processors   <= gfrtb_pkg::PROC_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      task_count   <= task_count_next;
      result_valid <= result_valid_next;
      if (cfg_wr_en) begin
        processors <= cfg_wr_data;
      end
    end
    idx       <= idx_next;
    i         <= i_next;
    acc       <= acc_next;
    wc        <= wc_next;
    wd        <= wd_next;
    res_bound <= res_bound_next;
    res_ovf   <= res_ovf_next;
    bound     <= bound_next;
    overflow  <= overflow_next;
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    task_count <= MAX_COUNT)
    else $error("task count past store capacity");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> bound == '0)
    else $error("overflow result with nonzero bound");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    task_valid && !task_stall |=> state != gfrtb_pkg::S_IDLE)
    else $error("accepted item did not start work");
`endif

endmodule

// ===== verif/tb_global_fp_response_time_bound_top.sv =====
`timescale 1ns / 100ps

module tb_global_fp_response_time_bound_top;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 500;
  localparam int unsigned PHASE_COUNT = 9;
  localparam int unsigned PHASE_ITEMS = 165;

  typedef struct packed {
    logic [gfrtb_pkg::VAL_W-1:0] bound;
    logic                        overflow;
  } bound_result_t;

  // Predicts the response time bound of each task against the stored task set
  class response_bound_model;
    logic [gfrtb_pkg::VAL_W-1:0]  c_store[STORE_DEPTH];
    logic [gfrtb_pkg::VAL_W-1:0]  p_store[STORE_DEPTH];
    logic [gfrtb_pkg::VAL_W-1:0]  r_store[STORE_DEPTH];
    int unsigned                  stored;
    logic [gfrtb_pkg::PROC_W-1:0] processors;
    bound_result_t                bounds_due[$];
    int unsigned                  mismatches;

    function new();
      stored = 0;
      processors = gfrtb_pkg::PROC_RESET;
      mismatches = 0;
    endfunction

    function void set_processors(logic [gfrtb_pkg::PROC_W-1:0] value);
      processors = value;
    endfunction

    // Workload of stored task i that can fall into a window of length t
    function int unsigned window_share(int unsigned i, int unsigned t);
      int          ci;
      int          pi;
      int          ri;
      int          x;
      int unsigned excess;
      int unsigned q;
      int unsigned rem;
      int unsigned sum;
      ci = int'(c_store[i]);
      pi = int'(p_store[i]);
      ri = int'(r_store[i]);
      if (pi == 0) return t;
      x = int'(t) - ci - pi + ri;
      excess = (x > 0) ? x : 0;
      q = excess / pi;
      rem = excess % pi;
      if (rem > ci) rem = ci;
      sum = ci + q * ci + rem;
      return (sum < t) ? sum : t;
    endfunction

    function void note_task(logic first, logic [gfrtb_pkg::VAL_W-1:0] c,
                            logic [gfrtb_pkg::VAL_W-1:0] p,
                            logic [gfrtb_pkg::VAL_W-1:0] d,
                            logic [gfrtb_pkg::VAL_W-1:0] r);
      int unsigned   m;
      int unsigned   idx;
      int unsigned   w;
      int unsigned   b;
      bound_result_t res;
      if (first) stored = 0;
      // Drop a task that does not fit; it is flagged and not analysed
      if (stored >= STORE_DEPTH) begin
        stored = STORE_DEPTH;
        res.bound = '0;
        res.overflow = 1'b1;
        bounds_due.push_back(res);
        return;
      end
      m = (processors == 0) ? 1 : 32'(processors);
      idx = stored;
      if (idx < m) begin
        b = 32'(c);
      end else begin
        w = 0;
        for (int unsigned i = 0; i < idx; i++) w += window_share(i, 32'(d));
        b = 32'(c) + w / m;
        if (b > 32'(d)) b = 32'(d);
      end
      c_store[idx] = c;
      p_store[idx] = p;
      r_store[idx] = r;
      stored = idx + 1;
      res.bound = b[gfrtb_pkg::VAL_W-1:0];
      res.overflow = 1'b0;
      bounds_due.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [gfrtb_pkg::VAL_W-1:0] bound, logic overflow);
      bound_result_t want;
      if (bounds_due.size() == 0) begin
        report_mismatch($sformatf("result with none due: bound=%0d overflow=%0b",
                                  bound, overflow));
        return;
      end
      want = bounds_due.pop_front();
      if (bound !== want.bound)
        report_mismatch($sformatf("bound %0d, expected %0d", bound, want.bound));
      if (overflow !== want.overflow)
        report_mismatch($sformatf("overflow %0b, expected %0b", overflow, want.overflow));
    endtask
  endclass

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [gfrtb_pkg::PROC_W-1:0] cfg_wr_data = '0;
  logic                         task_valid = 1'b0;
  logic                         task_stall;
  logic                         first_task = 1'b0;
  logic [gfrtb_pkg::VAL_W-1:0]  exec_time = '0;
  logic [gfrtb_pkg::VAL_W-1:0]  period = 8'd1;
  logic [gfrtb_pkg::VAL_W-1:0]  deadline = '0;
  logic [gfrtb_pkg::VAL_W-1:0]  own_bound = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [gfrtb_pkg::VAL_W-1:0]  bound;
  logic                         overflow;

  response_bound_model sb;
  int unsigned         sender_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         quiet_cycles = 0;

  global_fp_response_time_bound_top #(
    .MAX_TASKS(STORE_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .task_valid  (task_valid),
    .task_stall  (task_stall),
    .first_task  (first_task),
    .exec_time   (exec_time),
    .period      (period),
    .deadline    (deadline),
    .own_bound   (own_bound),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .bound       (bound),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check results first, then note the accepted task
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(bound, overflow);
    if (!rst && task_valid && !task_stall)
      sb.note_task(first_task, exec_time, period, deadline, own_bound);
  end

  // End the run once nothing has moved for too long
  always @(posedge clk) begin
    if ((task_valid && !task_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one task, idling at random first, and hold it until taken
  task automatic send_task(input logic first, input logic [gfrtb_pkg::VAL_W-1:0] c,
                           input logic [gfrtb_pkg::VAL_W-1:0] p,
                           input logic [gfrtb_pkg::VAL_W-1:0] d,
                           input logic [gfrtb_pkg::VAL_W-1:0] r);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      task_valid <= 1'b0;
      @(negedge clk);
    end
    task_valid <= 1'b1;
    first_task <= first;
    exec_time <= c;
    period <= p;
    deadline <= d;
    own_bound <= r;
    do @(posedge clk); while (task_stall);
  endtask

  // Hold off the sender until every due bound has come back
  task automatic drain_bounds();
    @(negedge clk);
    task_valid <= 1'b0;
    while (sb.bounds_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_processors(input logic [gfrtb_pkg::PROC_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    sb.set_processors(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Small, medium, high or full-range values so that caps and divisions vary
  function automatic logic [gfrtb_pkg::VAL_W-1:0] pick_value(input bit nonzero);
    logic [gfrtb_pkg::VAL_W-1:0] v;
    case ($urandom_range(3))
      0: v = 8'($urandom_range(255));
      1: v = 8'($urandom_range(15));
      2: v = 8'($urandom_range(63));
      default: v = 8'($urandom_range(255, 100));
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  // One task set in priority order; a few are noise with first_task at random
  task automatic run_task_set(input bit fill_past_store, output int unsigned sent);
    int unsigned len;
    int unsigned pick;
    bit          noisy;
    logic        first;
    pick = $urandom_range(99);
    if (fill_past_store || pick < 3) len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
    else if (pick < 10) len = $urandom_range(STORE_DEPTH, 21);
    else if (pick < 30) len = $urandom_range(20, 9);
    else len = $urandom_range(8, 1);
    noisy = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      first = noisy ? logic'($urandom_range(1)) : (i == 0);
      send_task(first, pick_value(1'b0), pick_value(1'b1), pick_value(1'b0),
                pick_value(1'b0));
    end
    sent = len;
  endtask

  initial begin
    logic [gfrtb_pkg::PROC_W-1:0] proc_plan[PHASE_COUNT];
    int unsigned                  phase_sent;
    int unsigned                  sent;
    sb = new();
    proc_plan = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd40, 7'd7, 7'd2, 7'd16, 7'd5};
    proc_plan[8] = 7'($urandom_range(64, 1));
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: no first_task after reset, field extremes, zero period
    send_task(1'b0, 8'd255, 8'd255, 8'd0, 8'd255);
    send_task(1'b0, 8'd0, 8'd1, 8'd255, 8'd0);
    send_task(1'b0, 8'd10, 8'd7, 8'd100, 8'd20);
    send_task(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_task(1'b0, 8'd5, 8'd0, 8'd50, 8'd0);
    send_task(1'b0, 8'd3, 8'd9, 8'd200, 8'd9);
    send_task(1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_task(1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_task(1'b1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_task(1'b0, 8'd200, 8'd3, 8'd0, 8'd0);
    send_task(1'b0, 8'd0, 8'd255, 8'd0, 8'd0);
    send_task(1'b0, 8'd128, 8'd128, 8'd128, 8'd128);
    send_task(1'b0, 8'd2, 8'd0, 8'd255, 8'd255);
    send_task(1'b0, 8'd7, 8'd11, 8'd255, 8'd0);
    send_task(1'b1, 8'd0, 8'd1, 8'd0, 8'd0);
    send_task(1'b1, 8'd255, 8'd1, 8'd255, 8'd0);
    drain_bounds();

    // Random: receiver-heavy idling, then sender-heavy, then none
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_bounds();
      write_processors(proc_plan[ph]);
      sender_idle_pct = (ph < 3) ? 38 : (ph < 6) ? 58 : 0;
      recv_idle_pct = (ph < 3) ? 58 : (ph < 6) ? 38 : 0;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        run_task_set((phase_sent == 0) && (ph % 3 == 1), sent);
        phase_sent += sent;
      end
    end

    drain_bounds();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.bounds_due.size() != 0)
      sb.report_mismatch($sformatf("%0d bounds never arrived", sb.bounds_due.size()));
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gfrtb_pkg.sv
hdl/gfrtb_store.sv
hdl/gfrtb_div.sv
hdl/global_fp_response_time_bound_top.sv
verif/tb_global_fp_response_time_bound_top.sv
